@@ rtl/kear_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kear_pkg
// Shared types and constants for the keypad edge and auto-repeat block.
// ----------------------------------------------------------------------------
package kear_pkg;

  localparam int unsigned KEY_W   = 10;
  localparam int unsigned TIMER_W = 8;
  localparam int unsigned IDLE_W  = 16;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [TIMER_W-1:0] timer_t;
  typedef logic [IDLE_W-1:0]  idle_t;
  typedef logic [CFG_W-1:0]   cfg_data_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Key bits: A 0, B 1, Select 2, Start 3, d-pad 4..7, R 8, L 9
  localparam key_t ABLR_MASK       = 10'h303;
  localparam key_t ACTIVE_KEY_MASK = 10'h3F3;
  localparam idle_t IDLE_MAX       = 16'hFFFF;

  localparam timer_t DELAY_RESET    = 8'd12;
  localparam timer_t INTERVAL_RESET = 8'd4;

  localparam cfg_idx_t REG_FIRST_WAIT  = 1'b0;
  localparam cfg_idx_t REG_AUTO_PERIOD = 1'b1;

  typedef struct packed {
    timer_t first_wait;
    timer_t auto_period;
  } cfg_t;

  typedef struct packed {
    key_t  held_keys;
    key_t  new_presses;
    key_t  repeat_presses;
    key_t  release_combo;
    key_t  alternate_presses;
    idle_t idle_frames;
  } res_t;

endpackage

@@ rtl/kear_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kear_in_if
// Key sample request channel: valid/ready handshake plus the frame's keys.
// ----------------------------------------------------------------------------
interface kear_in_if;
  logic                valid;
  logic                ready;
  kear_pkg::key_t      key_sample;

  modport source (output valid, output key_sample, input ready);
  modport sink   (input valid, input key_sample, output ready);
endinterface

@@ rtl/kear_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kear_out_if
// Result request channel: valid/ready handshake plus the per-frame results.
// ----------------------------------------------------------------------------
interface kear_out_if;
  logic                valid;
  logic                ready;
  kear_pkg::key_t      held_keys;
  kear_pkg::key_t      new_presses;
  kear_pkg::key_t      repeat_presses;
  kear_pkg::key_t      release_combo;
  kear_pkg::key_t      alternate_presses;
  kear_pkg::idle_t     idle_frames;

  modport source (output valid, output held_keys, output new_presses,
                  output repeat_presses, output release_combo,
                  output alternate_presses, output idle_frames, input ready);
  modport sink   (input valid, input held_keys, input new_presses,
                  input repeat_presses, input release_combo,
                  input alternate_presses, input idle_frames, output ready);
endinterface

@@ rtl/kear_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kear_in_stage
// Input register: holds one key sample until the step logic consumes it.
// ----------------------------------------------------------------------------
module kear_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  kear_pkg::key_t key_i,
  output logic           valid_o,
  input  logic           take_i,
  output kear_pkg::key_t key_o
);
  import kear_pkg::*;

  logic vld_q, vld_d;
  key_t key_q;

  assign ready_o = !vld_q || take_i;
  assign vld_d   = (valid_i && ready_o) || (vld_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      key_q <= key_i;
    end
  end

  assign valid_o = vld_q;
  assign key_o   = key_q;

endmodule

@@ rtl/kear_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kear_step
// Frame state and update logic: edge detect, auto-repeat timer, release
// combo, alternate mask and idle counter. State advances on commit.
// ----------------------------------------------------------------------------
module kear_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           commit_i,
  input  kear_pkg::key_t held_i,
  input  kear_pkg::cfg_t cfg_i,
  output kear_pkg::res_t res_o
);
  import kear_pkg::*;

  key_t   prior_q, prior_d;
  key_t   combo_q, combo_d;
  timer_t timer_q, timer_d;
  key_t   alt_q, alt_d;
  idle_t  idle_q, idle_d;

  key_t   fresh;
  key_t   rep;
  key_t   release_val;
  timer_t timer_dec;

  always_comb begin
    fresh   = held_i & ~prior_q;
    combo_d = (fresh != '0) ? held_i : combo_q;

    release_val = '0;
    if (held_i == '0 && combo_d != '0 && combo_d == (prior_q & ABLR_MASK)) begin
      release_val = prior_q;
    end

    // steady non-empty hold counts down; anything else rearms the delay
    rep       = fresh;
    timer_dec = timer_q - 1'b1;
    if (held_i != '0 && held_i == prior_q) begin
      if (timer_dec == '0) begin
        rep     = held_i;
        timer_d = cfg_i.auto_period;
      end else begin
        timer_d = timer_dec;
      end
    end else begin
      timer_d = cfg_i.first_wait;
    end

    alt_d = (held_i ^ alt_q) & held_i;

    if ((held_i & ACTIVE_KEY_MASK) != '0) begin
      idle_d = '0;
    end else if (idle_q != IDLE_MAX) begin
      idle_d = idle_q + 1'b1;
    end else begin
      idle_d = idle_q;
    end

    prior_d = held_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q <= '0;
      combo_q <= '0;
      timer_q <= '0;
      alt_q   <= '0;
      idle_q  <= '0;
    end else if (commit_i) begin
      prior_q <= prior_d;
      combo_q <= combo_d;
      timer_q <= timer_d;
      alt_q   <= alt_d;
      idle_q  <= idle_d;
    end
  end

  always_comb begin
    res_o.held_keys         = held_i;
    res_o.new_presses       = fresh;
    res_o.repeat_presses    = rep;
    res_o.release_combo     = release_val;
    res_o.alternate_presses = alt_d;
    res_o.idle_frames       = idle_d;
  end

endmodule

@@ rtl/kear_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kear_out_stage
// Result register: holds one result until the downstream sink takes it.
// ----------------------------------------------------------------------------
module kear_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  output logic           free_o,
  input  kear_pkg::res_t res_i,
  output logic           valid_o,
  input  logic           ready_i,
  output kear_pkg::res_t res_o
);
  import kear_pkg::*;

  logic vld_q, vld_d;
  res_t res_q;

  assign free_o = !vld_q || ready_i;
  assign vld_d  = load_i || (vld_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

@@ rtl/keypad_edge_and_auto_repeat.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_edge_and_auto_repeat
// Per-frame keypad processing with edge detect and auto-repeat.
// ----------------------------------------------------------------------------
// One key sample request per frame gives one result request. A sample sits
// in an input register and the frame update is combinational logic into
// the result register; the block takes a new sample every cycle while the
// sink keeps taking results. The frame state (previous keys, release combo,
// repeat timer, alternate mask, idle count) updates when a sample moves
// into the result register. The first-repeat wait (index 0, reset 12) and
// the auto-repeat period (index 1, reset 4) are written through the config
// port; the user must write them only while the block is idle, which the
// block itself does not enforce. A zero value means 256 frames.
// ----------------------------------------------------------------------------
module keypad_edge_and_auto_repeat (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  kear_pkg::cfg_idx_t    cfg_idx_i,
  input  kear_pkg::cfg_data_t   cfg_data_i,
  kear_in_if.sink               in_if,
  kear_out_if.source            out_if
);
  import kear_pkg::*;

  cfg_t cfg_q;
  logic in_vld;
  key_t in_key;
  logic out_free;
  logic advance;
  res_t step_res;
  res_t out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_wait  <= DELAY_RESET;
      cfg_q.auto_period <= INTERVAL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FIRST_WAIT:  cfg_q.first_wait  <= cfg_data_i;
        REG_AUTO_PERIOD: cfg_q.auto_period <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance = in_vld && out_free;

  kear_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_if.valid),
    .ready_o (in_if.ready),
    .key_i   (in_if.key_sample),
    .valid_o (in_vld),
    .take_i  (advance),
    .key_o   (in_key)
  );

  kear_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (advance),
    .held_i   (in_key),
    .cfg_i    (cfg_q),
    .res_o    (step_res)
  );

  kear_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .free_o  (out_free),
    .res_i   (step_res),
    .valid_o (out_if.valid),
    .ready_i (out_if.ready),
    .res_o   (out_res)
  );

  assign out_if.held_keys         = out_res.held_keys;
  assign out_if.new_presses       = out_res.new_presses;
  assign out_if.repeat_presses    = out_res.repeat_presses;
  assign out_if.release_combo     = out_res.release_combo;
  assign out_if.alternate_presses = out_res.alternate_presses;
  assign out_if.idle_frames       = out_res.idle_frames;

endmodule

@@ rtl/kear_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kear_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module kear_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input kear_pkg::key_t  held_keys_i,
  input kear_pkg::key_t  new_presses_i,
  input kear_pkg::key_t  repeat_presses_i,
  input kear_pkg::key_t  alternate_presses_i,
  input kear_pkg::idle_t idle_frames_i
);
  import kear_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(held_keys_i))
    else $error("result dropped or changed while stalled");

  a_press_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((new_presses_i | repeat_presses_i) & ~held_keys_i) == '0)
    else $error("press reported for a key that is not held");

  a_alt_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (alternate_presses_i & ~held_keys_i) == '0)
    else $error("alternate mask outside held keys");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((held_keys_i & ACTIVE_KEY_MASK) != '0) |-> idle_frames_i == '0)
    else $error("idle count not cleared by an active key");

endmodule

bind keypad_edge_and_auto_repeat kear_checker u_kear_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_i         (out_if.valid),
  .out_ready_i         (out_if.ready),
  .held_keys_i         (out_if.held_keys),
  .new_presses_i       (out_if.new_presses),
  .repeat_presses_i    (out_if.repeat_presses),
  .alternate_presses_i (out_if.alternate_presses),
  .idle_frames_i       (out_if.idle_frames)
);
